// ===== design/utf8_to_ascii_key_stream_defines.svh =====
// Assertion macros for the UTF-8 to ASCII key stream block.
`ifndef UTF8_TO_ASCII_KEY_STREAM_DEFINES_SVH
`define UTF8_TO_ASCII_KEY_STREAM_DEFINES_SVH

`ifndef ASSERT_OFF

// Check a condition on every clock edge outside reset.
`define U2A_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("u2a: invariant violated");

// Check that a condition implies another in the same cycle.
`define U2A_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("u2a: implication violated");

// Check that a condition implies another in the next cycle.
`define U2A_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("u2a: next-cycle implication violated");

`else

`define U2A_ASSERT(label, clk, rst, prop)
`define U2A_ASSERT_IMPL(label, clk, rst, ante, cons)
`define U2A_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== design/u2a_pkg.sv =====
// Types and constants shared by the UTF-8 to ASCII key stream modules.
package u2a_pkg;

   localparam int MaxTextBytes = 2048;
   localparam int CountLimitInt = (3 * MaxTextBytes < 8191) ? 3 * MaxTextBytes : 8191;
   localparam logic [12:0] CountLimit = 13'(CountLimitInt);

   localparam logic [1:0] KIND_CHAR   = 2'd0;
   localparam logic [1:0] KIND_RETURN = 2'd1;
   localparam logic [1:0] KIND_TAB    = 2'd2;

   localparam logic [7:0] CHR_TAB    = 8'h09;
   localparam logic [7:0] CHR_LF     = 8'h0A;
   localparam logic [7:0] CHR_CR     = 8'h0D;
   localparam logic [7:0] CHR_SPACE  = 8'h20;
   localparam logic [7:0] CHR_TILDE  = 8'h7E;
   localparam logic [6:0] CHR_APOS   = 7'h27;
   localparam logic [6:0] CHR_QUOTE  = 7'h22;
   localparam logic [6:0] CHR_DASH   = 7'h2D;
   localparam logic [6:0] CHR_DOT    = 7'h2E;

   localparam logic [7:0] NBSP_LEAD  = 8'hC2;
   localparam logic [7:0] NBSP_TRAIL = 8'hA0;
   localparam logic [7:0] PUNCT_LEAD = 8'hE2;
   localparam logic [7:0] PUNCT_MID  = 8'h80;
   localparam logic [7:0] LSQUO      = 8'h98;
   localparam logic [7:0] RSQUO      = 8'h99;
   localparam logic [7:0] LDQUO      = 8'h9C;
   localparam logic [7:0] RDQUO      = 8'h9D;
   localparam logic [7:0] EN_DASH    = 8'h93;
   localparam logic [7:0] EM_DASH    = 8'h94;
   localparam logic [7:0] ELLIPSIS   = 8'hA6;

   // Partial multi-byte sequence: lead byte, up to two trailing bytes.
   typedef struct packed {
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
      logic [1:0] cnt;
      logic [2:0] len;
   } pend_type;

   typedef struct packed {
      logic        char_valid;
      logic [6:0]  out_char;
      logic [1:0]  key_kind;
      logic        end_of_text;
      logic [12:0] char_count;
   } result_type;

   // All results caused by one input byte.
   typedef struct packed {
      result_type [3:0] item;
      logic [2:0]       num;
   } batch_type;

   typedef struct packed {
      pend_type   pend;
      logic [1:0] n_emit;
      logic [6:0] ch;
   } feed_type;

endpackage

// ===== design/u2a_decode.sv =====
// Per-byte decode: next sequence state, character count and result batch.
module u2a_decode
   import u2a_pkg::*;
(
   input  pend_type    pend,
   input  logic [12:0] emitted,
   input  logic [7:0]  in_byte,
   input  logic        last_byte,
   output pend_type    pend_next,
   output logic [12:0] emitted_next,
   output batch_type   batch
);

   function automatic feed_type feed(pend_type st, logic [7:0] c);
      feed_type   f;
      logic [2:0] nc;
      logic [7:0] x1;
      logic [7:0] x2;
      f        = '0;
      f.pend   = st;
      nc       = {1'b0, st.cnt} + 3'd1;
      x1       = (st.cnt == 2'd1) ? c : st.b1;
      x2       = (st.cnt == 2'd2) ? c : st.b2;
      if (st.cnt != 2'd0) begin
         if (nc >= st.len) begin
            f.pend = '0;
            priority if (st.len == 3'd2 && st.b0 == NBSP_LEAD && x1 == NBSP_TRAIL) begin
               f.n_emit = 2'd1;
               f.ch     = CHR_SPACE[6:0];
            end else if (st.len == 3'd3 && st.b0 == PUNCT_LEAD && x1 == PUNCT_MID) begin
               priority if (x2 == LSQUO || x2 == RSQUO) begin
                  f.n_emit = 2'd1;
                  f.ch     = CHR_APOS;
               end else if (x2 == LDQUO || x2 == RDQUO) begin
                  f.n_emit = 2'd1;
                  f.ch     = CHR_QUOTE;
               end else if (x2 == EN_DASH || x2 == EM_DASH) begin
                  f.n_emit = 2'd1;
                  f.ch     = CHR_DASH;
               end else if (x2 == ELLIPSIS) begin
                  f.n_emit = 2'd3;
                  f.ch     = CHR_DOT;
               end else begin
                  f.n_emit = 2'd0;
               end
            end else begin
               f.n_emit = 2'd0;
            end
         end else begin
            if (st.cnt == 2'd1) begin
               f.pend.b1 = c;
            end else begin
               f.pend.b2 = c;
            end
            f.pend.cnt = nc[1:0];
         end
      end else if (c == CHR_LF || c == CHR_CR || c == CHR_TAB ||
                   (c >= CHR_SPACE && c <= CHR_TILDE)) begin
         f.n_emit = 2'd1;
         f.ch     = c[6:0];
      end else if ((c & 8'hE0) == 8'hC0) begin
         f.pend     = '0;
         f.pend.b0  = c;
         f.pend.cnt = 2'd1;
         f.pend.len = 3'd2;
      end else if ((c & 8'hF0) == 8'hE0) begin
         f.pend     = '0;
         f.pend.b0  = c;
         f.pend.cnt = 2'd1;
         f.pend.len = 3'd3;
      end else if ((c & 8'hF8) == 8'hF0) begin
         f.pend     = '0;
         f.pend.b0  = c;
         f.pend.cnt = 2'd1;
         f.pend.len = 3'd4;
      end
      return f;
   endfunction

   function automatic result_type key_result(logic [6:0] ch);
      result_type r;
      r            = '0;
      r.char_valid = 1'b1;
      if (ch == CHR_LF[6:0] || ch == CHR_CR[6:0]) begin
         r.key_kind = KIND_RETURN;
      end else if (ch == CHR_TAB[6:0]) begin
         r.key_kind = KIND_TAB;
      end else begin
         r.key_kind = KIND_CHAR;
         r.out_char = ch;
      end
      return r;
   endfunction

   feed_type    fr [5];
   pend_type    s;
   pend_type    t;
   logic [6:0]  em [4];
   logic [2:0]  n;
   logic [13:0] sum;
   logic [12:0] sat;

   always_comb begin
      fr[0] = feed(pend, in_byte);
      for (int i = 1; i < 5; i++) begin
         fr[i] = '0;
      end
      s = fr[0].pend;
      t = '0;
      // On the last byte, drop a truncated lead and feed its tail bytes again;
      // two passes re-decode the tail bytes, and pend_next is cleared afterwards.
      if (last_byte) begin
         for (int it = 0; it < 2; it++) begin
            t = '0;
            if (s.cnt >= 2'd2) begin
               fr[1 + 2 * it] = feed(t, s.b1);
               t = fr[1 + 2 * it].pend;
            end
            if (s.cnt == 2'd3) begin
               fr[2 + 2 * it] = feed(t, s.b2);
               t = fr[2 + 2 * it].pend;
            end
            s = t;
         end
      end

      n = 3'd0;
      for (int j = 0; j < 4; j++) begin
         em[j] = '0;
      end
      for (int i = 0; i < 5; i++) begin
         for (int j = 0; j < 4; j++) begin
            if (3'(j) >= n && 3'(j) < n + {1'b0, fr[i].n_emit}) begin
               em[j] = fr[i].ch;
            end
         end
         n = n + {1'b0, fr[i].n_emit};
      end

      sum = {1'b0, emitted} + 14'(n);
      sat = (sum >= {1'b0, CountLimit}) ? CountLimit : sum[12:0];

      batch = '0;
      for (int j = 0; j < 4; j++) begin
         if (3'(j) < n) begin
            batch.item[j] = key_result(em[j]);
         end
      end
      batch.num = n;
      if (last_byte) begin
         batch.item[n[1:0]].end_of_text = 1'b1;
         batch.item[n[1:0]].char_count  = sat;
         batch.num = n + 3'd1;
      end

      pend_next    = last_byte ? '0 : s;
      emitted_next = last_byte ? '0 : sat;
   end

endmodule

// ===== design/utf8_to_ascii_key_stream.sv =====
// Top level of the UTF-8 to ASCII key stream converter.
// Takes UTF-8 text one byte per req_ transfer (req_last_byte marks the final
// byte) and gives key events on rsp_: printable ASCII as characters, newline
// and carriage return as Return, tab as Tab, curly quotes, dashes and the
// no-break space as their ASCII forms, and an ellipsis as three dots. Other
// multi-byte sequences are skipped by their lead-byte length. After the last
// byte a truncated sequence loses its lead byte and its tail bytes are
// decoded again, then one end result carries the saturating character count.
// Each accepted byte is decoded combinationally into a four-entry result
// register that drains one result per cycle while rsp_ready is high. A byte
// that yields at most one result lets the next byte in as that result drains
// (one byte per cycle sustained while rsp_ready is high); a byte that yields
// several results, such as an ellipsis or a last byte, holds the input until
// its final result drains. There is no clearing pass after reset.
`include "utf8_to_ascii_key_stream_defines.svh"

module utf8_to_ascii_key_stream
   import u2a_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_char_valid,
   output logic [6:0]  rsp_out_char,
   output logic [1:0]  rsp_key_kind,
   output logic        rsp_end_of_text,
   output logic [12:0] rsp_char_count
);

   pend_type         pend_ff;
   pend_type         pend_in;
   logic [12:0]      count_ff;
   logic [12:0]      count_in;
   result_type [3:0] res_ff;
   logic [2:0]       res_cnt_ff;
   batch_type        batch;
   logic             req_xfer;
   logic             rsp_xfer;

   u2a_decode u_decode (
      .pend         (pend_ff),
      .emitted      (count_ff),
      .in_byte      (req_in_byte),
      .last_byte    (req_last_byte),
      .pend_next    (pend_in),
      .emitted_next (count_in),
      .batch        (batch)
   );

   // Take a new byte once the result register is empty or drains its
   // final entry in this cycle.
   assign req_ready = (res_cnt_ff == 3'd0) || (res_cnt_ff == 3'd1 && rsp_ready);
   assign req_xfer  = req_valid && req_ready;
   assign rsp_valid = (res_cnt_ff != 3'd0);
   assign rsp_xfer  = rsp_valid && rsp_ready;

   // Control: sequence state, character count, result fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff    <= '0;
         count_ff   <= '0;
         res_cnt_ff <= '0;
      end else if (req_xfer) begin
         pend_ff    <= pend_in;
         count_ff   <= count_in;
         res_cnt_ff <= batch.num;
      end else if (rsp_xfer) begin
         res_cnt_ff <= res_cnt_ff - 3'd1;
      end
   end

   // Load a fresh batch on a byte transfer, else advance the queue on a
   // result transfer; the head entry always drives the outputs.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         res_ff <= batch.item;
      end else if (rsp_xfer) begin
         res_ff[0] <= res_ff[1];
         res_ff[1] <= res_ff[2];
         res_ff[2] <= res_ff[3];
      end
   end

   assign rsp_char_valid  = res_ff[0].char_valid;
   assign rsp_out_char    = res_ff[0].out_char;
   assign rsp_key_kind    = res_ff[0].key_kind;
   assign rsp_end_of_text = res_ff[0].end_of_text;
   assign rsp_char_count  = res_ff[0].char_count;

   // The result register never holds more than four entries.
   `U2A_ASSERT(a_fill_bound, clock, reset, res_cnt_ff <= 3'd4)
   // An end result is always the last entry of its batch.
   `U2A_ASSERT_IMPL(a_end_last, clock, reset, rsp_valid && rsp_end_of_text, res_cnt_ff == 3'd1)
   // A key event is never also an end result.
   `U2A_ASSERT_IMPL(a_key_not_end, clock, reset, rsp_valid && rsp_char_valid, !rsp_end_of_text)
   // The last byte of a text leaves no pending sequence and a zero count.
   `U2A_ASSERT_NEXT(a_text_reset, clock, reset, req_xfer && req_last_byte,
      pend_ff.cnt == 2'd0 && count_ff == 13'd0)

endmodule
